// ===== rtl/dms_pkg.sv =====
// shared constants, types and twiddle functions for the dft magnitude block
`default_nettype none
package dms_pkg;
   localparam int BlockSize = 512;
   localparam int PosW = $clog2(BlockSize);
   localparam int SampW = 16;
   localparam int TwW = 16;
   localparam int MagW = 25;
   localparam int BinW = 8;
   localparam int AccW = SampW + TwW + PosW + 1;
   localparam int ShW = AccW - 15;
   localparam int SqW = 2 * ShW;
   localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

   typedef struct packed {
      logic [PosW-1:0] bin;
      logic            last;
   } job_type;

   // round(32767*sin(2*pi*t/N)) with ties away from zero
   function automatic logic signed [TwW-1:0] sin_q15(input int t);
      real v;
      int r;
      v = 32767.0 * $sin(2.0 * 3.14159265358979323846 * t / BlockSize);
      if (v >= 0.0) r = int'($floor(v + 0.5));
      else r = -int'($floor(-v + 0.5));
      return TwW'(r);
   endfunction

   function automatic logic signed [TwW-1:0] cos_q15(input int t);
      real v;
      int r;
      v = 32767.0 * $cos(2.0 * 3.14159265358979323846 * t / BlockSize);
      if (v >= 0.0) r = int'($floor(v + 0.5));
      else r = -int'($floor(-v + 0.5));
      return TwW'(r);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/dms_front.sv =====
// front end: sample store writes, bank swap and bin job issue
`default_nettype none
module dms_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [dms_pkg::SampW-1:0]   sample,
   output logic                             wr_en,
   output logic [dms_pkg::PosW:0]           wr_addr,
   output logic [dms_pkg::SampW-1:0]        wr_data,
   output logic                             rd_bank,
   output logic                             job_valid,
   output dms_pkg::job_type                 job,
   input  wire logic                        job_full,
   input  wire logic                        bank_busy
);
   logic [dms_pkg::PosW-1:0] pos_ff, pos_in;
   logic bank_ff, bank_in, ready_ff, ready_in;
   logic acc;
   logic want;
   logic swap_hold;

   assign want = ready_ff && !pos_ff[dms_pkg::PosW-1];
   // the swap beat waits until the back end has stopped reading the completed bank
   assign swap_hold = bank_busy && (pos_ff == dms_pkg::PosW'(dms_pkg::BlockSize - 1));
   assign full = (want && job_full) || swap_hold;
   assign acc = push && !full;
   assign wr_en = acc;
   assign wr_addr = {bank_ff, pos_ff};
   assign wr_data = sample;
   assign rd_bank = ~bank_ff;
   assign job_valid = acc && want;
   assign job.bin = pos_ff;
   assign job.last = (pos_ff == dms_pkg::PosW'(dms_pkg::BlockSize / 2 - 1));

   always_comb begin
      pos_in = pos_ff;
      bank_in = bank_ff;
      ready_in = ready_ff;
      if (acc) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == dms_pkg::PosW'(dms_pkg::BlockSize - 1)) begin
            bank_in = ~bank_ff;
            ready_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         bank_ff <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         bank_ff <= bank_in;
         ready_ff <= ready_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/dms_back.sv =====
// back end: sample memory, correlation accumulators and iterative square root
`default_nettype none
module dms_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [dms_pkg::PosW:0]      wr_addr,
   input  wire logic [dms_pkg::SampW-1:0]   wr_data,
   input  wire logic                        rd_bank,
   input  wire logic                        job_valid,
   input  wire dms_pkg::job_type            job,
   output logic                             job_full,
   output logic                             bank_busy,
   output logic                             res_valid,
   output logic [dms_pkg::MagW-1:0]         res_mag,
   output logic [dms_pkg::BinW-1:0]         res_bin,
   output logic                             res_last,
   input  wire logic                        res_take
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_MAC = 5'b00010, S_SQ = 5'b00100,
      S_ROOT = 5'b01000, S_OUT = 5'b10000
   } state_type;

   localparam int PW = dms_pkg::PosW;
   localparam int AW = dms_pkg::AccW;
   localparam int SW = dms_pkg::SqW;

   logic signed [dms_pkg::SampW-1:0] mem [0:2*dms_pkg::BlockSize-1];
   logic signed [dms_pkg::SampW-1:0] rd_ff;
   logic signed [dms_pkg::TwW-1:0] sin_tab [dms_pkg::BlockSize];
   logic signed [dms_pkg::TwW-1:0] cos_tab [dms_pkg::BlockSize];
   logic signed [dms_pkg::TwW-1:0] sw_ff, cw_ff;

   // two-entry job queue
   dms_pkg::job_type q_ff [2];
   logic [1:0] qcnt_ff;
   logic qrd_ff;
   logic qwr_ff;

   state_type st_ff;
   dms_pkg::job_type cur_ff;
   logic [PW:0] n_ff;
   logic [PW-1:0] th_ff;
   logic vld_ff;
   logic signed [AW-1:0] re_ff, im_ff;
   logic [SW-1:0] v_ff, res_ff, bit_ff;
   logic [2:0] sqc_ff;
   logic signed [dms_pkg::ShW-1:0] a_sh, b_sh;
   logic [dms_pkg::ShW-1:0] ua_ff, ub_ff;
   logic [SW-1:0] sq_ff;
   logic [dms_pkg::MagW-1:0] mag_ff;
   logic pop_q;

   for (genvar t = 0; t < dms_pkg::BlockSize; t++) begin : g_tab
      assign sin_tab[t] = dms_pkg::sin_q15(t);
      assign cos_tab[t] = dms_pkg::cos_q15(t);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[{rd_bank, n_ff[PW-1:0]}];
      sw_ff <= sin_tab[th_ff];
      cw_ff <= cos_tab[th_ff];
   end

   assign job_full = (qcnt_ff == 2'd2);
   // completed bank still needed while jobs wait or the mac walks it
   assign bank_busy = (qcnt_ff != 2'd0) || (st_ff == S_MAC);
   assign pop_q = (st_ff == S_IDLE) && (qcnt_ff != 2'd0);
   assign a_sh = re_ff[AW-1:15];
   assign b_sh = im_ff[AW-1:15];

   always_ff @(posedge clock) begin
      if (job_valid) q_ff[qwr_ff] <= job;
      if (reset) begin
         qcnt_ff <= '0;
         qrd_ff <= 1'b0;
         qwr_ff <= 1'b0;
      end else begin
         if (job_valid) qwr_ff <= ~qwr_ff;
         if (pop_q) qrd_ff <= ~qrd_ff;
         qcnt_ff <= qcnt_ff + {1'b0, job_valid} - {1'b0, pop_q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            S_IDLE: if (pop_q) begin
               cur_ff <= q_ff[qrd_ff];
               n_ff <= '0;
               th_ff <= '0;
               vld_ff <= 1'b0;
               re_ff <= '0;
               im_ff <= '0;
               st_ff <= S_MAC;
            end
            S_MAC: begin
               // table read and memory read are registered, landing in the cycle after the address
               if (vld_ff) begin
                  re_ff <= re_ff + AW'(rd_ff * sw_ff);
                  im_ff <= im_ff + AW'(rd_ff * cw_ff);
               end
               if (n_ff == (PW+1)'(dms_pkg::BlockSize)) begin
                  vld_ff <= 1'b0;
                  if (!vld_ff) begin
                     st_ff <= S_SQ;
                     sqc_ff <= '0;
                  end
               end else begin
                  vld_ff <= 1'b1;
                  n_ff <= n_ff + 1'b1;
                  th_ff <= th_ff + cur_ff.bin;
               end
            end
            S_SQ: begin
               sqc_ff <= sqc_ff + 1'b1;
               unique case (sqc_ff)
                  3'd0: begin
                     ua_ff <= a_sh[dms_pkg::ShW-1] ? -a_sh : a_sh;
                     ub_ff <= b_sh[dms_pkg::ShW-1] ? -b_sh : b_sh;
                  end
                  3'd1: sq_ff <= SW'(ua_ff) * SW'(ua_ff);
                  3'd2: begin
                     v_ff <= sq_ff;
                     sq_ff <= SW'(ub_ff) * SW'(ub_ff);
                  end
                  default: begin
                     v_ff <= v_ff + sq_ff;
                     res_ff <= '0;
                     bit_ff <= {2'b01, {(SW-2){1'b0}}};
                     st_ff <= S_ROOT;
                  end
               endcase
            end
            S_ROOT: begin
               if (bit_ff == '0) begin
                  mag_ff <= (res_ff > SW'(dms_pkg::MagMax)) ? dms_pkg::MagMax
                                                         : res_ff[dms_pkg::MagW-1:0];
                  st_ff <= S_OUT;
               end else begin
                  if (v_ff >= res_ff + bit_ff) begin
                     v_ff <= v_ff - (res_ff + bit_ff);
                     res_ff <= (res_ff >> 1) + bit_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_OUT: if (res_take) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign res_valid = (st_ff == S_OUT);
   assign res_mag = mag_ff;
   assign res_bin = dms_pkg::BinW'(cur_ff.bin);
   assign res_last = cur_ff.last;
endmodule
`default_nettype wire

// ===== rtl/dft_magnitude_spectrum_top.sv =====
// top level of the direct dft magnitude spectrum block
// usage:
//   req_ channel: one signed 16-bit sample a beat, taken when push is high
//   and full low. every sample goes into the filling half of a two-bank
//   sample memory; after 512 samples the banks swap.
//   once a block exists, the beat at fill position j < 256 also queues a job
//   for dft bin j of the completed block.
//   rsp_ channel: queue-style (empty/pop); a beat carries the magnitude,
//   bin number and last-bin flag.
//   a bin's path after its beat: the back end picks up the job, runs the
//   multiply-accumulate (one sample a cycle through the memory read port),
//   squares both sums and takes an iterative square root; it takes the next
//   job only once the result has been popped.
//   a two-entry job queue sits between front and back; full rises when a
//   bin beat arrives with the queue full, and on the last sample of a block
//   while the back end still needs the completed bank, so stalling the
//   receiver eventually holds off the sender.
//   reset clears fill position, bank select, block-ready flag, job queue and
//   the back-end state; sample memory is not cleared.
`default_nettype none
module dft_magnitude_spectrum_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [15:0]                 req_sample,
   output logic                             empty,
   input  wire logic                        pop,
   output logic [24:0]                      rsp_magnitude,
   output logic [7:0]                       rsp_bin_index,
   output logic                             rsp_last_bin
);
   logic wr_en, rd_bank, job_valid, job_full, res_valid, bank_busy;
   logic [dms_pkg::PosW:0] wr_addr;
   logic [dms_pkg::SampW-1:0] wr_data;
   dms_pkg::job_type job;

   // front: store and classify beats
   dms_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .sample(req_sample), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_bank(rd_bank), .job_valid(job_valid),
      .job(job), .job_full(job_full), .bank_busy(bank_busy)
   );

   // back: correlate, root, hold result until popped
   dms_back u_back (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_bank(rd_bank), .job_valid(job_valid),
      .job(job), .job_full(job_full), .bank_busy(bank_busy),
      .res_valid(res_valid), .res_mag(rsp_magnitude),
      .res_bin(rsp_bin_index), .res_last(rsp_last_bin), .res_take(pop)
   );

   assign empty = ~res_valid;
endmodule
`default_nettype wire
